/* sv/xrng_pkg.sv */
`timescale 1ns / 1ps

package xrng_pkg;

  // command codes on in_cmd
  localparam logic [2:0] CMD_SET_SEED  = 3'd0;
  localparam logic [2:0] CMD_FEAT_SEED = 3'd1;
  localparam logic [2:0] CMD_NEXT_LONG = 3'd2;
  localparam logic [2:0] CMD_NEXT_INT  = 3'd3;
  localparam logic [2:0] CMD_NEXT_FLT  = 3'd4;
  localparam logic [2:0] CMD_NEXT_DBL  = 3'd5;

  localparam logic [63:0] K_SILVER = 64'h6a09e667f3bcc909;
  localparam logic [63:0] K_GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] K_MIXA   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] K_MIXB   = 64'h94d049bb133111eb;
  localparam logic [13:0] SALT_B_SCALE = 14'd10000;

  localparam logic [4:0] DIV_STEPS = 5'd31;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SEED_RES,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_MIX_MID,
    OP_END_LO,
    OP_END_HI,
    OP_ADV,
    OP_RES_RAW,
    OP_RES_DHI,
    OP_RES_DLO,
    OP_RES_ZERO,
    OP_TAKE_U,
    OP_MULN,
    OP_RES_POW,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_RES_REM,
    OP_PUSH
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MA0,
    ST_MA1,
    ST_MA2,
    ST_MID,
    ST_MB0,
    ST_MB1,
    ST_MB2,
    ST_END,
    ST_FIN,
    ST_D_HI,
    ST_D_ADV,
    ST_D_LO,
    ST_NI_U,
    ST_NI_SEL,
    ST_NI_POW,
    ST_NI_DIV,
    ST_NI_CHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t  op;
    logic ksel_b;
  } ctrl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       pow2;
    logic       div_done;
    logic       reject;
    logic       out_busy;
  } stat_t;

endpackage

/* sv/xrng_ctrl.sv */
`timescale 1ns / 1ps

module xrng_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  xrng_pkg::stat_t stat,
  output xrng_pkg::ctrl_t ctrl
);

  xrng_pkg::state_t state_r, state_nxt;
  logic phase_r, phase_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xrng_pkg::ST_IDLE;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign in_stall = (state_r != xrng_pkg::ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    ctrl.op     = xrng_pkg::OP_NONE;
    ctrl.ksel_b = 1'b0;
    case (state_r)
      xrng_pkg::ST_IDLE: begin
        if (in_valid) begin
          ctrl.op   = xrng_pkg::OP_LOAD;
          state_nxt = xrng_pkg::ST_DISPATCH;
        end
      end
      xrng_pkg::ST_DISPATCH: begin
        phase_nxt = 1'b0;
        case (stat.cmd)
          xrng_pkg::CMD_SET_SEED, xrng_pkg::CMD_FEAT_SEED: begin
            ctrl.op   = xrng_pkg::OP_SEED_RES;
            state_nxt = xrng_pkg::ST_MA0;
          end
          xrng_pkg::CMD_NEXT_LONG, xrng_pkg::CMD_NEXT_FLT: begin
            ctrl.op   = xrng_pkg::OP_ADV;
            state_nxt = xrng_pkg::ST_FIN;
          end
          xrng_pkg::CMD_NEXT_INT: begin
            ctrl.op   = xrng_pkg::OP_ADV;
            state_nxt = xrng_pkg::ST_NI_U;
          end
          xrng_pkg::CMD_NEXT_DBL: begin
            ctrl.op   = xrng_pkg::OP_ADV;
            state_nxt = xrng_pkg::ST_D_HI;
          end
          default: begin
            ctrl.op   = xrng_pkg::OP_RES_ZERO;
            state_nxt = xrng_pkg::ST_DONE;
          end
        endcase
      end
      // mix64: two truncated 64x64 multiplies, three partial products each
      xrng_pkg::ST_MA0: begin
        ctrl.op = xrng_pkg::OP_MUL0; state_nxt = xrng_pkg::ST_MA1;
      end
      xrng_pkg::ST_MA1: begin
        ctrl.op = xrng_pkg::OP_MUL1; state_nxt = xrng_pkg::ST_MA2;
      end
      xrng_pkg::ST_MA2: begin
        ctrl.op = xrng_pkg::OP_MUL2; state_nxt = xrng_pkg::ST_MID;
      end
      xrng_pkg::ST_MID: begin
        ctrl.op = xrng_pkg::OP_MIX_MID; state_nxt = xrng_pkg::ST_MB0;
      end
      xrng_pkg::ST_MB0: begin
        ctrl.op = xrng_pkg::OP_MUL0; ctrl.ksel_b = 1'b1; state_nxt = xrng_pkg::ST_MB1;
      end
      xrng_pkg::ST_MB1: begin
        ctrl.op = xrng_pkg::OP_MUL1; ctrl.ksel_b = 1'b1; state_nxt = xrng_pkg::ST_MB2;
      end
      xrng_pkg::ST_MB2: begin
        ctrl.op = xrng_pkg::OP_MUL2; ctrl.ksel_b = 1'b1; state_nxt = xrng_pkg::ST_END;
      end
      xrng_pkg::ST_END: begin
        if (phase_r) begin
          ctrl.op   = xrng_pkg::OP_END_HI;
          state_nxt = xrng_pkg::ST_DONE;
        end else begin
          ctrl.op   = xrng_pkg::OP_END_LO;
          phase_nxt = 1'b1;
          state_nxt = xrng_pkg::ST_MA0;
        end
      end
      xrng_pkg::ST_FIN: begin
        ctrl.op = xrng_pkg::OP_RES_RAW; state_nxt = xrng_pkg::ST_DONE;
      end
      // double: 26 high bits, then 27 low bits from the next output
      xrng_pkg::ST_D_HI: begin
        ctrl.op = xrng_pkg::OP_RES_DHI; state_nxt = xrng_pkg::ST_D_ADV;
      end
      xrng_pkg::ST_D_ADV: begin
        ctrl.op = xrng_pkg::OP_ADV; state_nxt = xrng_pkg::ST_D_LO;
      end
      xrng_pkg::ST_D_LO: begin
        ctrl.op = xrng_pkg::OP_RES_DLO; state_nxt = xrng_pkg::ST_DONE;
      end
      // bounded int
      xrng_pkg::ST_NI_U: begin
        ctrl.op = xrng_pkg::OP_TAKE_U; state_nxt = xrng_pkg::ST_NI_SEL;
      end
      xrng_pkg::ST_NI_SEL: begin
        if (stat.pow2) begin
          ctrl.op   = xrng_pkg::OP_MULN;
          state_nxt = xrng_pkg::ST_NI_POW;
        end else begin
          ctrl.op   = xrng_pkg::OP_DIV_INIT;
          state_nxt = xrng_pkg::ST_NI_DIV;
        end
      end
      xrng_pkg::ST_NI_POW: begin
        ctrl.op = xrng_pkg::OP_RES_POW; state_nxt = xrng_pkg::ST_DONE;
      end
      xrng_pkg::ST_NI_DIV: begin
        if (stat.div_done) begin
          state_nxt = xrng_pkg::ST_NI_CHK;
        end else begin
          ctrl.op = xrng_pkg::OP_DIV_STEP;
        end
      end
      xrng_pkg::ST_NI_CHK: begin
        if (stat.reject) begin
          ctrl.op   = xrng_pkg::OP_ADV;
          state_nxt = xrng_pkg::ST_NI_U;
        end else begin
          ctrl.op   = xrng_pkg::OP_RES_REM;
          state_nxt = xrng_pkg::ST_DONE;
        end
      end
      xrng_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          ctrl.op   = xrng_pkg::OP_PUSH;
          state_nxt = xrng_pkg::ST_IDLE;
        end
      end
      default: state_nxt = xrng_pkg::ST_IDLE;
    endcase
  end

endmodule

/* sv/xrng_dp.sv */
`timescale 1ns / 1ps

module xrng_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  xrng_pkg::ctrl_t ctrl,
  output xrng_pkg::stat_t stat,
  input  logic [2:0]      in_cmd,
  input  logic [63:0]     in_seed_value,
  input  logic [15:0]     in_salt_a,
  input  logic [15:0]     in_salt_b,
  input  logic [30:0]     in_bound,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [63:0]     out_result
);

  logic [2:0]  cmd_r;
  logic [63:0] seed_r, fseed_r;
  logic [30:0] bound_r;
  logic [63:0] sl_r, sl_nxt, sh_r, sh_nxt;
  logic [63:0] t_r, m_r, acc_r, raw_r, res_r;
  logic [30:0] u_r, q_r, rem_r;
  logic [4:0]  cnt_r;
  logic        out_valid_r;
  logic [63:0] out_result_r;

  logic [63:0] k, adv_sum, adv_raw, adv_bx, s_pick, t_new, t_hi;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [29:0] salt_prod;
  logic [31:0] bound32, m32, rem_try, rej_sum;

  function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned s);
    rotl = (v << s) | (v >> (64 - s));
  endfunction

  // shared 32x32 multiplier
  assign k = ctrl.ksel_b ? xrng_pkg::K_MIXB : xrng_pkg::K_MIXA;
  always_comb begin
    case (ctrl.op)
      xrng_pkg::OP_MUL1: begin mul_a = m_r[63:32]; mul_b = k[31:0];  end
      xrng_pkg::OP_MUL2: begin mul_a = m_r[31:0];  mul_b = k[63:32]; end
      xrng_pkg::OP_MULN: begin mul_a = {1'b0, bound_r}; mul_b = {1'b0, u_r}; end
      default:           begin mul_a = m_r[31:0];  mul_b = k[31:0];  end
    endcase
  end
  assign prod = {32'd0, mul_a} * {32'd0, mul_b};

  // generator step
  assign adv_sum = sl_r + sh_r;
  assign adv_raw = rotl(adv_sum, 17) + sl_r;
  assign adv_bx  = sh_r ^ sl_r;

  // seed forming and mix inputs
  assign salt_prod = 30'({14'd0, in_salt_b} * {16'd0, xrng_pkg::SALT_B_SCALE});
  assign s_pick    = (cmd_r == xrng_pkg::CMD_FEAT_SEED) ? fseed_r : seed_r;
  assign t_new     = s_pick ^ xrng_pkg::K_SILVER;
  assign t_hi      = t_r + xrng_pkg::K_GOLDEN;

  // modulo step and rejection test
  assign bound32 = {1'b0, bound_r};
  assign m32     = bound32 - 32'd1;
  assign rem_try = {rem_r, q_r[30]};
  assign rej_sum = {1'b0, u_r} - {1'b0, rem_r} + m32;

  assign stat.cmd      = cmd_r;
  assign stat.pow2     = ((bound32 & m32) == 32'd0);
  assign stat.div_done = (cnt_r == 5'd0);
  assign stat.reject   = rej_sum[31];
  assign stat.out_busy = out_valid_r && out_stall;

  always_comb begin
    sl_nxt = sl_r;
    sh_nxt = sh_r;
    case (ctrl.op)
      xrng_pkg::OP_ADV: begin
        sl_nxt = rotl(sl_r, 49) ^ adv_bx ^ (adv_bx << 21);
        sh_nxt = rotl(adv_bx, 28);
      end
      xrng_pkg::OP_END_LO: sl_nxt = acc_r ^ (acc_r >> 31);
      xrng_pkg::OP_END_HI: sh_nxt = acc_r ^ (acc_r >> 31);
      default: ;
    endcase
  end

  // generator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sl_r <= 64'd0;
      sh_r <= 64'd0;
    end else begin
      sl_r <= sl_nxt;
      sh_r <= sh_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (ctrl.op)
      xrng_pkg::OP_LOAD: begin
        cmd_r   <= in_cmd;
        seed_r  <= in_seed_value;
        fseed_r <= in_seed_value + {48'd0, in_salt_a} + {34'd0, salt_prod};
        bound_r <= in_bound;
      end
      xrng_pkg::OP_SEED_RES: begin
        res_r <= s_pick;
        t_r   <= t_new;
        m_r   <= t_new ^ (t_new >> 30);
      end
      xrng_pkg::OP_MUL0:    acc_r <= prod;
      xrng_pkg::OP_MUL1,
      xrng_pkg::OP_MUL2:    acc_r <= acc_r + {prod[31:0], 32'd0};
      xrng_pkg::OP_MIX_MID: m_r <= acc_r ^ (acc_r >> 27);
      xrng_pkg::OP_END_LO:  m_r <= t_hi ^ (t_hi >> 30);
      xrng_pkg::OP_ADV:     raw_r <= adv_raw;
      xrng_pkg::OP_RES_RAW:
        res_r <= (cmd_r == xrng_pkg::CMD_NEXT_FLT) ? (raw_r >> 40) : raw_r;
      xrng_pkg::OP_RES_DHI: res_r <= (raw_r >> 38) << 27;
      xrng_pkg::OP_RES_DLO: res_r <= res_r + (raw_r >> 37);
      xrng_pkg::OP_RES_ZERO: res_r <= 64'd0;
      xrng_pkg::OP_TAKE_U:  u_r <= raw_r[63:33];
      xrng_pkg::OP_MULN:    acc_r <= prod;
      xrng_pkg::OP_RES_POW: res_r <= acc_r >> 31;
      xrng_pkg::OP_DIV_INIT: begin
        q_r   <= u_r;
        rem_r <= 31'd0;
      end
      xrng_pkg::OP_DIV_STEP: begin
        q_r <= {q_r[29:0], 1'b0};
        if (rem_try >= bound32) rem_r <= 31'(rem_try - bound32);
        else                    rem_r <= rem_try[30:0];
      end
      xrng_pkg::OP_RES_REM: res_r <= {33'd0, rem_r};
      default: ;
    endcase
  end

  // modulo step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 5'd0;
    end else if (ctrl.op == xrng_pkg::OP_DIV_INIT) begin
      cnt_r <= xrng_pkg::DIV_STEPS;
    end else if (ctrl.op == xrng_pkg::OP_DIV_STEP) begin
      cnt_r <= cnt_r - 5'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.op == xrng_pkg::OP_PUSH) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == xrng_pkg::OP_PUSH) out_result_r <= res_r;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

/* sv/xoroshiro_rng_with_bounded_draws.sv */
`timescale 1ns / 1ps
// xoroshiro128++ generator with seeding and bounded draws.
// Input channel (in_valid / in_stall): one command per transfer, with
// in_cmd, in_seed_value, in_salt_a, in_salt_b and in_bound. The block takes
// one command at a time; in_stall is high while a command is in progress.
// Output channel (out_valid / out_stall): one out_result per command, held
// in an output register, so the next command is taken while it waits.
// Steps per command, from acceptance to result in the output register:
//   next long / float: one advance; next double: two advances, high bits
//   then low bits; unused codes: a zero result; set seed / feature seed:
//   two mix64 passes, each two 64-bit multiplies built from three 32x32
//   partial products on one multiplier; next int, power-of-two bound: an
//   advance and a multiply by the bound; other bounds: a bit-serial modulo,
//   redone with a new draw for each rejected draw. Then back to idle. If the
//   result register is still held by out_stall, the result waits until it frees up.
// Reset (rst_n low, synchronous) clears the state words to zero and
// empties the output register.
module xoroshiro_rng_with_bounded_draws (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [63:0] in_seed_value,
  input  logic [15:0] in_salt_a,
  input  logic [15:0] in_salt_b,
  input  logic [30:0] in_bound,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result
);

  xrng_pkg::ctrl_t ctrl;
  xrng_pkg::stat_t stat;

  xrng_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  xrng_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .stat          (stat),
    .in_cmd        (in_cmd),
    .in_seed_value (in_seed_value),
    .in_salt_a     (in_salt_a),
    .in_salt_b     (in_salt_b),
    .in_bound      (in_bound),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_result    (out_result)
  );

endmodule
